>>> rtl/ilt_pkg.sv
// ilt_pkg: shared types, byte codes and limits for the ini line tokenizer
// no dependencies; imported by every ilt module and by ilt_rsp_if
package ilt_pkg;

   // chunk bound: a full chunk holds MAX_LINE-1 bytes, its last byte sits at MAX_LINE-2
   localparam int unsigned MAX_LINE = 256;
   localparam int unsigned POS_W = 8;
   localparam logic [POS_W:0] LINE_LIMIT = (POS_W + 1)'(MAX_LINE - 1);

   localparam logic [7:0] CHAR_NUL      = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_SEMI     = 8'h3B;
   localparam logic [7:0] CHAR_EQUAL    = 8'h3D;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] VISIBLE_MIN   = 8'd33;

   typedef enum logic [1:0] {
      KIND_IGNORED = 2'd0,
      KIND_KEY     = 2'd1,
      KIND_SECTION = 2'd2
   } line_kind_type;

   typedef enum logic [5:0] {
      PH_SCAN         = 6'b000001,
      PH_VALUE        = 6'b000010,
      PH_VALUE_DONE   = 6'b000100,
      PH_SECTION      = 6'b001000,
      PH_SECTION_DONE = 6'b010000,
      PH_IGNORE       = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       stream_end;
   } req_item_type;

   typedef struct packed {
      line_kind_type    line_kind;
      logic [POS_W-1:0] name_first;
      logic [POS_W-1:0] name_last;
      logic             value_present;
      logic [POS_W-1:0] value_first;
      logic [POS_W-1:0] value_last;
   } rsp_item_type;

endpackage

>>> rtl/ilt_req_if.sv
// ilt_req_if: valid/ready channel carrying one text byte per beat
// no package dependency; the byte and end flag are plain logic
interface ilt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       stream_end;

   modport source (output valid, output text_byte, output stream_end, input ready);
   modport sink (input valid, input text_byte, input stream_end, output ready);
endinterface

>>> rtl/ilt_rsp_if.sv
// ilt_rsp_if: valid/ready channel carrying one line result per beat
// depends on ilt_pkg for the offset width
interface ilt_rsp_if import ilt_pkg::*;;
   logic             valid;
   logic             ready;
   logic [1:0]       line_kind;
   logic [POS_W-1:0] name_first;
   logic [POS_W-1:0] name_last;
   logic             value_present;
   logic [POS_W-1:0] value_first;
   logic [POS_W-1:0] value_last;

   modport source (output valid, output line_kind, output name_first, output name_last,
                   output value_present, output value_first, output value_last,
                   input ready);
   modport sink (input valid, input line_kind, input name_first, input name_last,
                 input value_present, input value_first, input value_last,
                 output ready);
endinterface

>>> rtl/ini_line_tokenizer_top.sv
// ini_line_tokenizer_top: streaming ini line tokenizer, top level
// depends on ilt_pkg, ilt_req_if, ilt_rsp_if, ilt_in_reg, ilt_scan, ilt_out_reg
//
//  channel    dir  beat contents                                   handshake
//  req_chan   in   text_byte[7:0], stream_end                      valid/ready
//  rsp_chan   out  line_kind[1:0], name_first/last[7:0],           valid/ready
//                  value_present, value_first/last[7:0]
//
// one text byte per cycle sustained while rsp_chan does not stall; a result
// for the byte that closes its chunk passes through the input register, then
// scan logic into the result register
// the scan state (offset, phase, spans) is updated once per byte, which sets
// the one-byte-per-cycle rate
// synchronous reset clears the chunk state and both valid flags; no clearing
// pass is needed
// a stalled result register holds the byte in the input register, and the
// input register still takes a beat while it is empty
// bytes that do not close a chunk produce no beat on rsp_chan
module ini_line_tokenizer_top import ilt_pkg::*; (
   input logic       clock,
   input logic       reset,
   ilt_req_if.sink   req_chan,
   ilt_rsp_if.source rsp_chan
);

   logic         advance;
   logic         step_en;
   req_item_type item;
   logic         rsp_fire;
   rsp_item_type rsp_item;

   // input register: one accepted byte waiting for the scanner
   ilt_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .step_en  (step_en),
      .item     (item)
   );

   // chunk state machine and offset tracking
   ilt_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .item     (item),
      .rsp_fire (rsp_fire),
      .rsp_item (rsp_item)
   );

   // result register: holds a waiting result; the scanner stalls until it is taken
   ilt_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .rsp_fire (rsp_fire),
      .rsp_item (rsp_item),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/ilt_in_reg.sv
// ilt_in_reg: input register stage holding one accepted text byte
// depends on ilt_pkg and ilt_req_if
module ilt_in_reg import ilt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ilt_req_if.sink      req_chan,
   input  logic         advance,
   output logic         step_en,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         accept;

   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in           = 1'b1;
         item_in.text_byte  = req_chan.text_byte;
         item_in.stream_end = req_chan.stream_end;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign step_en = valid_ff && advance;
   assign item    = item_ff;

endmodule

>>> rtl/ilt_scan.sv
// ilt_scan: per-byte chunk state, classification and trimmed offsets
// depends on ilt_pkg
module ilt_scan import ilt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   output logic         rsp_fire,
   output rsp_item_type rsp_item
);

   logic [POS_W-1:0] offset_ff, offset_in;
   phase_type        phase_ff, phase_in, phase_upd;
   logic             name_seen_ff, name_seen_in, name_seen_upd;
   logic [POS_W-1:0] name_start_ff, name_start_in, name_start_upd;
   logic [POS_W-1:0] name_end_ff, name_end_in, name_end_upd;
   logic             value_seen_ff, value_seen_in, value_seen_upd;
   logic [POS_W-1:0] value_start_ff, value_start_in, value_start_upd;
   logic [POS_W-1:0] value_end_ff, value_end_in, value_end_upd;

   logic             vis;
   logic             chunk_end;
   logic [POS_W:0]   pos_next;
   line_kind_type    kind;

   assign vis      = item.text_byte >= VISIBLE_MIN;
   assign pos_next = {1'b0, offset_ff} + (POS_W + 1)'(1);

   always_comb begin
      phase_upd       = phase_ff;
      name_seen_upd   = name_seen_ff;
      name_start_upd  = name_start_ff;
      name_end_upd    = name_end_ff;
      value_seen_upd  = value_seen_ff;
      value_start_upd = value_start_ff;
      value_end_upd   = value_end_ff;

      if (item.text_byte == CHAR_NUL) begin
         // nul ends the content of the chunk
         unique case (phase_ff)
            PH_SCAN:    phase_upd = PH_IGNORE;
            PH_VALUE:   phase_upd = PH_VALUE_DONE;
            PH_SECTION: phase_upd = PH_SECTION_DONE;
            default:    phase_upd = phase_ff;
         endcase
      end else begin
         unique case (phase_ff)
            PH_SCAN: begin
               if (item.text_byte == CHAR_SEMI) begin
                  phase_upd = PH_IGNORE;
               end else if (item.text_byte == CHAR_EQUAL) begin
                  phase_upd = name_seen_ff ? PH_VALUE : PH_IGNORE;
               end else if (item.text_byte == CHAR_LBRACKET) begin
                  name_seen_upd  = 1'b0;
                  name_start_upd = '0;
                  name_end_upd   = '0;
                  phase_upd      = PH_SECTION;
               end else if (vis) begin
                  if (!name_seen_ff) begin
                     name_seen_upd  = 1'b1;
                     name_start_upd = offset_ff;
                  end
                  name_end_upd = offset_ff;
               end
            end
            PH_VALUE: begin
               if (item.text_byte == CHAR_SEMI) begin
                  phase_upd = PH_VALUE_DONE;
               end else if (vis) begin
                  if (!value_seen_ff) begin
                     value_seen_upd  = 1'b1;
                     value_start_upd = offset_ff;
                  end
                  value_end_upd = offset_ff;
               end
            end
            PH_SECTION: begin
               if (item.text_byte == CHAR_SEMI) begin
                  phase_upd = PH_IGNORE;
               end else if (item.text_byte == CHAR_RBRACKET) begin
                  phase_upd = PH_SECTION_DONE;
               end else if (vis) begin
                  if (!name_seen_ff) begin
                     name_seen_upd  = 1'b1;
                     name_start_upd = offset_ff;
                  end
                  name_end_upd = offset_ff;
               end
            end
            default: phase_upd = phase_ff;
         endcase
      end
   end

   assign chunk_end = item.stream_end || (item.text_byte == CHAR_NEWLINE) ||
                      (pos_next >= LINE_LIMIT);

   always_comb begin
      if (phase_upd == PH_VALUE || phase_upd == PH_VALUE_DONE) begin
         kind = KIND_KEY;
      end else if ((phase_upd == PH_SECTION || phase_upd == PH_SECTION_DONE) &&
                   name_seen_upd) begin
         kind = KIND_SECTION;
      end else begin
         kind = KIND_IGNORED;
      end

      rsp_item.line_kind = kind;
      if (kind != KIND_IGNORED) begin
         rsp_item.name_first = name_start_upd;
         rsp_item.name_last  = name_end_upd;
      end else begin
         rsp_item.name_first = '0;
         rsp_item.name_last  = '0;
      end
      if (kind == KIND_KEY && value_seen_upd) begin
         rsp_item.value_present = 1'b1;
         rsp_item.value_first   = value_start_upd;
         rsp_item.value_last    = value_end_upd;
      end else begin
         rsp_item.value_present = 1'b0;
         rsp_item.value_first   = '0;
         rsp_item.value_last    = '0;
      end
   end

   assign rsp_fire = step_en && chunk_end;

   always_comb begin
      if (chunk_end) begin
         offset_in      = '0;
         phase_in       = PH_SCAN;
         name_seen_in   = 1'b0;
         name_start_in  = '0;
         name_end_in    = '0;
         value_seen_in  = 1'b0;
         value_start_in = '0;
         value_end_in   = '0;
      end else begin
         offset_in      = pos_next[POS_W-1:0];
         phase_in       = phase_upd;
         name_seen_in   = name_seen_upd;
         name_start_in  = name_start_upd;
         name_end_in    = name_end_upd;
         value_seen_in  = value_seen_upd;
         value_start_in = value_start_upd;
         value_end_in   = value_end_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff      <= '0;
         phase_ff       <= PH_SCAN;
         name_seen_ff   <= 1'b0;
         name_start_ff  <= '0;
         name_end_ff    <= '0;
         value_seen_ff  <= 1'b0;
         value_start_ff <= '0;
         value_end_ff   <= '0;
      end else if (step_en) begin
         offset_ff      <= offset_in;
         phase_ff       <= phase_in;
         name_seen_ff   <= name_seen_in;
         name_start_ff  <= name_start_in;
         name_end_ff    <= name_end_in;
         value_seen_ff  <= value_seen_in;
         value_start_ff <= value_start_in;
         value_end_ff   <= value_end_in;
      end
   end

   // a chunk end always restarts the offset count
   a_offset_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> offset_ff == '0)
      else $error("offset not cleared after chunk end");

   // the offset never walks past the last slot of a full chunk
   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, offset_ff} < LINE_LIMIT)
      else $error("chunk offset beyond line limit");

   // a value span only exists behind a key
   a_value_needs_key: assert property (@(posedge clock) disable iff (reset)
      value_seen_ff |-> (phase_ff == PH_VALUE || phase_ff == PH_VALUE_DONE))
      else $error("value span outside key phase");

   // name span is ordered once recorded
   a_name_order: assert property (@(posedge clock) disable iff (reset)
      name_seen_ff |-> name_start_ff <= name_end_ff)
      else $error("name span out of order");

endmodule

>>> rtl/ilt_out_reg.sv
// ilt_out_reg: result register decoupling the scanner from the result channel
// depends on ilt_pkg and ilt_rsp_if
module ilt_out_reg import ilt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_fire,
   input  rsp_item_type rsp_item,
   output logic         advance,
   ilt_rsp_if.source    rsp_chan
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign advance = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (advance) begin
         valid_in = rsp_fire;
         if (rsp_fire) begin
            item_in = rsp_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.line_kind     = item_ff.line_kind;
   assign rsp_chan.name_first    = item_ff.name_first;
   assign rsp_chan.name_last     = item_ff.name_last;
   assign rsp_chan.value_present = item_ff.value_present;
   assign rsp_chan.value_first   = item_ff.value_first;
   assign rsp_chan.value_last    = item_ff.value_last;

   // a result is only ever loaded into an empty or draining register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_chan.ready) |=> valid_ff)
      else $error("pending result dropped");

endmodule
